// ===== sv/fbt_pkg.sv =====
package fbt_pkg;

	localparam int FRONTIER_W = 64;
	localparam int POS_W      = 5;

	// cell codes of the frontier
	localparam logic [1:0] CELL_EMPTY  = 2'd0;
	localparam logic [1:0] CELL_SINGLE = 2'd1;
	localparam logic [1:0] CELL_OPEN   = 2'd2;
	localparam logic [1:0] CELL_CLOSE  = 2'd3;

	typedef struct packed {
		logic [FRONTIER_W-1:0] frontier;
		logic [POS_W-1:0]      position;
	} fbt_in_t;

	typedef struct packed {
		logic [FRONTIER_W-1:0] next_frontier;
		logic                  valid_res;
	} fbt_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN
	} fbt_state_t;

endpackage

// ===== sv/frontier_bracket_transition.sv =====
// Frontier bracket transition: one horizontal-edge step on a row of two-bit
// frontier cells (empty, single end, open bracket, close bracket).
//
// Command channel: req is taken at a rising edge where start is high and
// busy is low. busy stays high until the result has been formed.
// Result channel: res is valid for exactly one cycle, marked by done. The
// receiver cannot hold it off; a new beat may be taken in that same cycle.
//
// Timing: a decode state reads the cell pair at position. Pairs that need
// no partner search raise done straight from the decode state. Merges
// walk the frontier one cell per cycle from the pair towards the partner
// bracket, visiting 1 to CELLS-1 cells before done is raised. A new item
// is taken only once the last one is through, so the cell walk sets the
// rate of items.
//
// Reset (arst_n low) drops any item in flight and clears done and busy.
module frontier_bracket_transition
	import fbt_pkg::*;
#(
	parameter int CELLS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  fbt_in_t  req,
	output logic     done,
	output fbt_out_t res
);

	localparam int KW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DW = $clog2(CELLS + 1);

	fbt_state_t state_q, state_d;
	logic [FRONTIER_W-1:0] f_q;
	logic [POS_W-1:0]      pos_q;
	logic [KW-1:0]         k_q, k_d;
	logic [DW-1:0]         depth_q, depth_d;
	logic                  dir_q, dir_d;   // 1: walk leftwards
	logic [1:0]            val_q, val_d;
	fbt_out_t              res_q, res_d;
	logic                  done_q, done_d;

	logic [1:0]   cell_w [CELLS];
	logic [POS_W:0] pos_p1;
	logic         oor;
	logic [KW-1:0] pos_i, pos_i1;
	logic [1:0]   l_c, r_c, c_c;
	logic         inc, dec, found, at_end;
	logic [DW-1:0] depth_n;
	logic         accept;

	function automatic logic [FRONTIER_W-1:0] set_cells(
		input logic [FRONTIER_W-1:0] f,
		input logic [KW-1:0] ka, input logic [1:0] va,
		input logic [KW-1:0] kb, input logic [1:0] vb,
		input logic [KW-1:0] kc, input logic [1:0] vc,
		input logic          c_en
	);
		logic [FRONTIER_W-1:0] g;
		g = f;
		for (int i = 0; i < CELLS; i++) begin
			if (c_en && KW'(i) == kc) g[2*i +: 2] = vc;
			if (KW'(i) == kb) g[2*i +: 2] = vb;
			if (KW'(i) == ka) g[2*i +: 2] = va;
		end
		return g;
	endfunction

	always_comb begin
		for (int i = 0; i < CELLS; i++) cell_w[i] = f_q[2*i +: 2];
	end

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign res    = res_q;

	assign pos_p1 = {1'b0, pos_q} + (POS_W+1)'(1);
	assign oor    = pos_p1 >= (POS_W+1)'(CELLS);
	assign pos_i  = pos_q[KW-1:0];
	assign pos_i1 = pos_i + KW'(1);
	assign l_c    = cell_w[pos_i];
	assign r_c    = cell_w[pos_i1];

	// nest count towards the partner: rises on brackets facing away from it
	assign c_c     = cell_w[k_q];
	assign inc     = dir_q ? (c_c == CELL_CLOSE) : (c_c == CELL_OPEN);
	assign dec     = dir_q ? (c_c == CELL_OPEN) : (c_c == CELL_CLOSE);
	assign depth_n = depth_q + DW'(inc) - DW'(dec);
	assign found   = (depth_n == '0);
	assign at_end  = dir_q ? (k_q == '0) : (k_q == KW'(CELLS - 1));

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		depth_d = depth_q;
		dir_d   = dir_q;
		val_d   = val_q;
		res_d   = res_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				done_d  = 1'b1;
				res_d.next_frontier = f_q;
				res_d.valid_res     = 1'b1;
				priority if (oor) begin
					res_d.valid_res = 1'b0;
				end else if (l_c == CELL_EMPTY && r_c == CELL_EMPTY) begin
					res_d.next_frontier = set_cells(f_q, pos_i, CELL_OPEN,
						pos_i1, CELL_CLOSE, pos_i, CELL_EMPTY, 1'b0);
				end else if (l_c == CELL_CLOSE && r_c == CELL_OPEN) begin
					res_d.next_frontier = set_cells(f_q, pos_i, CELL_EMPTY,
						pos_i1, CELL_SINGLE, pos_i, CELL_EMPTY, 1'b0);
				end else if (l_c == CELL_EMPTY) begin
					res_d.next_frontier = set_cells(f_q, pos_i, r_c,
						pos_i1, CELL_SINGLE, pos_i, CELL_EMPTY, 1'b0);
				end else if (r_c == CELL_EMPTY) begin
					res_d.next_frontier = set_cells(f_q, pos_i, CELL_EMPTY,
						pos_i1, l_c, pos_i, CELL_EMPTY, 1'b0);
				end else if (l_c == CELL_CLOSE) begin
					// walk left for the matching open bracket
					state_d = ST_SCAN;
					done_d  = 1'b0;
					dir_d   = 1'b1;
					val_d   = r_c;
					k_d     = pos_i;
					depth_d = '0;
				end else if (r_c == CELL_OPEN) begin
					// walk right for the matching close bracket
					state_d = ST_SCAN;
					done_d  = 1'b0;
					dir_d   = 1'b0;
					val_d   = l_c;
					k_d     = pos_i1;
					depth_d = '0;
				end else begin
					res_d.valid_res = 1'b0;
				end
			end
			ST_SCAN: begin
				depth_d = depth_n;
				if (found || at_end) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
					res_d.next_frontier = set_cells(f_q, pos_i, CELL_EMPTY,
						pos_i1, CELL_SINGLE, k_q, val_q, found);
					res_d.valid_res     = 1'b1;
				end else begin
					k_d = dir_q ? (k_q - KW'(1)) : (k_q + KW'(1));
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_q   <= req.frontier;
			pos_q <= req.position;
		end
		k_q     <= k_d;
		depth_q <= depth_d;
		dir_q   <= dir_d;
		val_q   <= val_d;
		res_q   <= res_d;
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted beat");

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_DECODE || $past(state_q) == ST_SCAN))
		else $error("result strobe without an item at work");

	a_reject_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.valid_res) |-> (res.next_frontier == f_q))
		else $error("rejected beat altered the frontier");

	a_scan_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && dir_q) |-> (k_q <= pos_q[KW-1:0]))
		else $error("left walk passed the pair");

	a_scan_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !dir_q) |-> (k_q > pos_q[KW-1:0]))
		else $error("right walk passed the pair");
`endif

endmodule
